>>> sv/rphs_pkg.sv
// Package for the root pointer hash set: sizes, opcode and status codes,
// controller states and the command and status structs. No dependencies.
package rphs_pkg;

   localparam int SLOTS      = 1024;
   localparam int KEY_BITS   = 32;
   localparam int IDX_W      = $clog2(SLOTS);
   localparam int USED_W     = 11;
   localparam int HOME_SHIFT = 3;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_BADKEY = 2'd2;

   localparam logic [KEY_BITS-1:0] SLOT_EMPTY = KEY_BITS'(0);
   localparam logic [KEY_BITS-1:0] SLOT_TOMB  = KEY_BITS'(1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL,
      ST_CHECK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clr_en;   // write one empty slot of the clearing pass
      logic ready;    // input channel may take a transaction
      logic load;     // a transaction is taken this cycle
      logic start;    // screen the request and read its home slot
      logic step;     // examine the slot just read
      logic emit;     // move the result into the output register
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic early;
      logic probe_done;
      logic out_free;
   } status_type;

endpackage

>>> sv/rphs_if.sv
// Channel interfaces for the request and response transactions.
// Depends on rphs_pkg for the key and count widths.
interface rphs_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   opcode;
   logic [rphs_pkg::KEY_BITS-1:0] key;
   modport source (output valid, output opcode, output key, input ready);
   modport sink (input valid, input opcode, input key, output ready);
endinterface

interface rphs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        found;
   logic [1:0]                  status;
   logic [rphs_pkg::USED_W-1:0] used_slots;
   modport source (output valid, output found, output status, output used_slots,
                   input ready);
   modport sink (input valid, input found, input status, input used_slots,
                 output ready);
endinterface

>>> sv/rphs_ctrl.sv
// Controller state machine for the hash set: clearing pass, accept, probe, reply.
// Depends on rphs_pkg for the state enum and the command and status structs.
module rphs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  rphs_pkg::status_type stat,
   output rphs_pkg::cmd_type    cmd
);

   rphs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rphs_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rphs_pkg::ST_CLEAR: begin
            if (stat.clr_last) state_in = rphs_pkg::ST_IDLE;
         end
         rphs_pkg::ST_IDLE: begin
            if (req_valid) state_in = rphs_pkg::ST_EVAL;
         end
         rphs_pkg::ST_EVAL: begin
            state_in = stat.early ? rphs_pkg::ST_FINISH : rphs_pkg::ST_CHECK;
         end
         rphs_pkg::ST_CHECK: begin
            if (stat.probe_done) state_in = rphs_pkg::ST_FINISH;
         end
         rphs_pkg::ST_FINISH: begin
            if (stat.out_free) state_in = rphs_pkg::ST_IDLE;
         end
         default: state_in = rphs_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         rphs_pkg::ST_CLEAR: cmd.clr_en = 1'b1;
         rphs_pkg::ST_IDLE: begin
            cmd.ready = 1'b1;
            cmd.load  = req_valid;
         end
         rphs_pkg::ST_EVAL:   cmd.start = 1'b1;
         rphs_pkg::ST_CHECK:  cmd.step  = 1'b1;
         rphs_pkg::ST_FINISH: cmd.emit  = stat.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

>>> sv/rphs_dp.sv
// Datapath for the hash set: slot memory, probe index, used count and the
// output register. Depends on rphs_pkg; driven by rphs_ctrl commands.
module rphs_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  rphs_pkg::cmd_type              cmd,
   output rphs_pkg::status_type           stat,
   input  logic [1:0]                     req_opcode,
   input  logic [rphs_pkg::KEY_BITS-1:0]  req_key,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_found,
   output logic [1:0]                     rsp_status,
   output logic [rphs_pkg::USED_W-1:0]    rsp_used_slots
);

   localparam int IW = rphs_pkg::IDX_W;
   localparam int KW = rphs_pkg::KEY_BITS;
   localparam int UW = rphs_pkg::USED_W;

   logic [KW-1:0] mem [rphs_pkg::SLOTS];

   logic [IW-1:0] clr_ff;
   logic [1:0]    op_ff;
   logic [KW-1:0] key_ff;
   logic [IW-1:0] idx_ff;
   logic [IW-1:0] probes_ff;
   logic [KW-1:0] rdata_ff;
   logic [UW-1:0] used_ff;
   logic          found_ff;
   logic [1:0]    res_status_ff;
   logic          out_valid_ff;
   logic          out_found_ff;
   logic [1:0]    out_status_ff;
   logic [UW-1:0] out_used_ff;

   logic [IW-1:0] home;
   logic [IW-1:0] rd_addr;
   logic          bad_key, table_full, early;
   logic          slot_free, slot_empty, slot_match, at_cap;
   logic          done, wr_en, bump_used;
   logic [KW-1:0] wr_data;
   logic          done_found;
   logic [1:0]    done_status;

   assign home       = key_ff[rphs_pkg::HOME_SHIFT +: IW];
   assign bad_key    = (key_ff[KW-1:1] == '0);
   assign table_full = ({1'b0, used_ff, 1'b0} >= (UW + 2)'(rphs_pkg::SLOTS - 1));
   assign early      = bad_key || (op_ff == rphs_pkg::OP_INSERT && table_full) ||
                       (op_ff != rphs_pkg::OP_INSERT && op_ff != rphs_pkg::OP_QUERY &&
                        op_ff != rphs_pkg::OP_REMOVE);

   assign slot_empty = (rdata_ff == rphs_pkg::SLOT_EMPTY);
   assign slot_free  = (rdata_ff[KW-1:1] == '0);
   assign slot_match = (rdata_ff == key_ff);
   assign at_cap     = (probes_ff == {IW{1'b1}});

   // Decide what the slot just read means for the operation in hand.
   always_comb begin
      done        = 1'b0;
      wr_en       = 1'b0;
      wr_data     = key_ff;
      bump_used   = 1'b0;
      done_found  = 1'b0;
      done_status = rphs_pkg::STATUS_OK;
      case (op_ff)
         rphs_pkg::OP_INSERT: begin
            if (slot_free) begin
               done      = 1'b1;
               wr_en     = 1'b1;
               bump_used = slot_empty;
            end else if (at_cap) begin
               done        = 1'b1;
               done_status = rphs_pkg::STATUS_FULL;
            end
         end
         rphs_pkg::OP_QUERY, rphs_pkg::OP_REMOVE: begin
            // A match in the last slot of the probe still counts as a hit.
            if (slot_empty) begin
               done = 1'b1;
            end else if (slot_match) begin
               done       = 1'b1;
               done_found = 1'b1;
               wr_en      = (op_ff == rphs_pkg::OP_REMOVE);
               wr_data    = rphs_pkg::SLOT_TOMB;
            end else if (at_cap) begin
               done = 1'b1;
            end
         end
         default: done = 1'b1;
      endcase
   end

   assign rd_addr = cmd.start ? home : idx_ff + IW'(1);

   // Slot memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.clr_en) begin
         mem[clr_ff] <= rphs_pkg::SLOT_EMPTY;
      end else if (cmd.step && wr_en) begin
         mem[idx_ff] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         used_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_en) clr_ff <= clr_ff + IW'(1);
         if (cmd.step && done && bump_used) used_ff <= used_ff + UW'(1);
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         key_ff <= req_key;
      end
      if (cmd.start) begin
         idx_ff        <= home;
         probes_ff     <= '0;
         found_ff      <= 1'b0;
         res_status_ff <= bad_key ? rphs_pkg::STATUS_BADKEY :
                          (op_ff == rphs_pkg::OP_INSERT) ? rphs_pkg::STATUS_FULL :
                          rphs_pkg::STATUS_OK;
      end else if (cmd.step) begin
         if (done) begin
            found_ff      <= done_found;
            res_status_ff <= done_status;
         end else begin
            idx_ff    <= idx_ff + IW'(1);
            probes_ff <= probes_ff + IW'(1);
         end
      end
      if (cmd.emit) begin
         out_found_ff  <= found_ff;
         out_status_ff <= res_status_ff;
         out_used_ff   <= used_ff;
      end
   end

   assign stat.clr_last   = (clr_ff == {IW{1'b1}});
   assign stat.early      = early;
   assign stat.probe_done = done;
   assign stat.out_free   = !out_valid_ff || rsp_ready;

   assign rsp_valid      = out_valid_ff;
   assign rsp_found      = out_found_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_used_slots = out_used_ff;

endmodule

>>> sv/root_pointer_hash_set_unit.sv
// Top level of the root pointer hash set: joins controller and datapath to
// the request and response channels. Depends on rphs_pkg, rphs_if, rphs_ctrl, rphs_dp.
//
//   channel  direction  carries
//   req      in         opcode, key
//   rsp      out        found, status, used_slots
//
// After acceptance a transaction is screened while its home slot is read, then
// probed one slot per cycle from the slot memory until done; the result then goes
// to the output register. Screened requests (bad key, full table, unused opcode)
// skip the probe. After reset a clearing pass writes every slot empty, req.ready low.
// A result waits in the output register while the next request is accepted and
// probed; the block stalls only when a second result is ready before the first is taken.
module root_pointer_hash_set_unit (
   input logic        clock,
   input logic        reset,
   rphs_req_if.sink   req,
   rphs_rsp_if.source rsp
);

   rphs_pkg::cmd_type    cmd;
   rphs_pkg::status_type stat;

   rphs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   rphs_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_opcode     (req.opcode),
      .req_key        (req.key),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .rsp_found      (rsp.found),
      .rsp_status     (rsp.status),
      .rsp_used_slots (rsp.used_slots)
   );

   assign req.ready = cmd.ready;

endmodule
